/* src/tpcdt_pkg.sv */
// ----------------------------------------------------------------------------
// tpcdt_pkg: shared types and constants
// Widths, store geometry and the divider interface for the coverage/depth block.
// ----------------------------------------------------------------------------
package tpcdt_pkg;

	localparam int unsigned MaxWidth   = 1024;
	localparam int unsigned MaxHeight  = 1024;
	localparam int unsigned StoreWords = MaxWidth * MaxHeight;
	localparam int unsigned AddrW      = $clog2(StoreWords);
	localparam int unsigned DepthW     = 24;
	localparam int unsigned WeightW    = 17;
	// edge values fit in 35 bits signed; positive edges in 34 bits
	localparam int unsigned EdgeW      = 36;
	localparam int unsigned MagW       = 36;
	localparam int unsigned NumW       = MagW + 16;
	localparam logic [DepthW-1:0] DepthMax = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DEPTH,
		ST_WRITE
	} state_t;

	typedef enum logic {
		ACT_CLEAR = 1'b0,
		ACT_TEST  = 1'b1
	} action_t;

endpackage

/* src/tpcdt_div.sv */
// ----------------------------------------------------------------------------
// tpcdt_div: restoring divider
// Computes floor((num << 16) / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpcdt_div
	import tpcdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MagW-1:0]      num,
	input  logic [MagW-1:0]      den,
	output logic                 done,
	output logic [WeightW-1:0]   quo
);

	localparam int unsigned CntW = $clog2(NumW + 1);

	logic [NumW-1:0]  dividend_q;
	logic [MagW:0]    rem_q;
	logic [MagW-1:0]  den_q;
	logic [CntW-1:0]  cnt_q;
	logic             run_q;
	logic [MagW:0]    trial;
	logic [MagW:0]    diff;

	assign trial = {rem_q[MagW-1:0], dividend_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {num, 16'd0};
			rem_q      <= '0;
			den_q      <= den;
		end else if (run_q) begin
			if (!diff[MagW]) begin
				rem_q      <= diff;
				dividend_q <= {dividend_q[NumW-2:0], 1'b1};
			end else begin
				rem_q      <= trial;
				dividend_q <= {dividend_q[NumW-2:0], 1'b0};
			end
		end
	end

	// weights never exceed 1.0, so the low bits hold the quotient
	assign quo = dividend_q[WeightW-1:0];

endmodule

/* src/triangle_pixel_cover_depth_test_top.sv */
// ----------------------------------------------------------------------------
// triangle_pixel_cover_depth_test_top: pixel coverage and z-buffer test
// Edge-function coverage, barycentric weights and depth compare/update.
// ----------------------------------------------------------------------------
// Items are taken one at a time while busy is low. A clear item goes straight to
// the store write and then shows its result. An uncovered test item passes
// through edge products, edge difference and coverage decision, then reports.
// A covered test item sends the three weights one after another through a
// single bit-per-cycle divider, followed by depth products, the depth sum, a
// wait step and the store write. The depth store (one synchronous RAM with a
// registered read) is read during the divide and written at the end. busy drops
// in the cycle that shows the result. Each result is shown for exactly one cycle
// with done high; the receiver cannot stall it.
// The depth store has no reset: entries read before written give undefined depth.
module triangle_pixel_cover_depth_test_top
	import tpcdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [10:0]          cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic                 action,
	input  logic [9:0]           pixel_x,
	input  logic [9:0]           pixel_y,
	input  logic signed [15:0]   ax,
	input  logic signed [15:0]   ay,
	input  logic signed [15:0]   bx,
	input  logic signed [15:0]   by_coord,
	input  logic signed [15:0]   cx,
	input  logic signed [15:0]   cy,
	input  logic [DepthW-1:0]    recip_depth_a,
	input  logic [DepthW-1:0]    recip_depth_b,
	input  logic [DepthW-1:0]    recip_depth_c,
	output logic                 done,
	output logic                 covered,
	output logic                 depth_written,
	output logic [DepthW-1:0]    pixel_depth,
	output logic [WeightW-1:0]   weight_a,
	output logic [WeightW-1:0]   weight_b,
	output logic [WeightW-1:0]   weight_c
);

	logic [10:0] frame_width_q;

	// item registers
	logic              act_q;
	logic [AddrW-1:0]  addr_q;
	logic [AddrW-1:0]  addr_c;
	logic signed [17:0] ex_s[3], ey_s[3], qx_s[3], qy_s[3];
	logic signed [EdgeW-1:0] edge_q[3];
	logic [DepthW-1:0] rd_q[3];
	logic [WeightW-1:0] w_q[3];
	logic [1:0]        widx_q;
	logic [1:0]        div_idx;
	logic [MagW-1:0]   total_q;
	logic [DepthW-1:0] depth_q;
	logic [DepthW-1:0] stored_q;
	logic [2:0]        phase_q;   // 0 edge products, 1 edge difference, 2 decision
	logic              run_q;
	logic              div_start;
	logic              div_done;
	logic              div_busy_q;
	logic [WeightW-1:0] div_quo;
	logic [41:0]       prod_q[3];
	logic              dp_q;
	logic [DepthW-1:0] store_mem[StoreWords];
	logic              mem_we;
	logic [DepthW-1:0] mem_wdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) frame_width_q <= 11'd1024;
		else if (cfg_we) frame_width_q <= cfg_wdata;
	end

	// store address, wraps modulo the store size
	logic [21:0] addr_full;
	assign addr_full = 22'(pixel_x) + 22'(pixel_y) * 22'(frame_width_q);
	assign addr_c    = addr_full[AddrW-1:0];

	state_t state_q, state_d;
	assign busy = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = (action == ACT_TEST) ? ST_DIV : ST_WRITE;
			ST_DIV:   if (!run_q) state_d = ST_IDLE;
			          else if (div_done && widx_q == 2'd2) state_d = ST_DEPTH;
			ST_DEPTH: if (dp_q) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// edge phases, coverage decision, weight sequencing and depth phases
	logic signed [EdgeW-1:0] tot_c;
	assign tot_c = edge_q[0] + edge_q[1] + edge_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= '0;
			widx_q  <= '0;
			dp_q    <= 1'b0;
		end else begin
			dp_q <= 1'b0;
			if (state_q == ST_IDLE) begin
				run_q   <= start && action == ACT_TEST;
				phase_q <= 3'd0;
				widx_q  <= 2'd0;
			end else if (state_q == ST_DIV && phase_q < 3'd3) begin
				phase_q <= phase_q + 1'b1;
				if (phase_q == 3'd2 &&
				    (edge_q[0] < 0 || edge_q[1] < 0 || edge_q[2] < 0 || tot_c <= 0))
					run_q <= 1'b0;
			end else if (state_q == ST_DIV && div_done) begin
				widx_q <= widx_q + 1'b1;
			end else if (state_q == ST_DEPTH) begin
				phase_q <= phase_q + 1'b1;
				if (phase_q == 3'd5) dp_q <= 1'b1;
			end
		end
	end

	assign div_start = (state_q == ST_DIV) && run_q &&
		((phase_q == 3'd3 && widx_q == 2'd0 && !div_busy_q) || (div_done && widx_q != 2'd2));
	// a restart on done takes the next edge
	assign div_idx = (div_done && widx_q != 2'd2) ? widx_q + 2'd1 : widx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_busy_q <= 1'b0;
		else if (state_q != ST_DIV) div_busy_q <= 1'b0;
		else if (div_start) div_busy_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q <= action;
			addr_q <= addr_c;
			rd_q[0] <= recip_depth_a;
			rd_q[1] <= recip_depth_b;
			rd_q[2] <= recip_depth_c;
			ex_s[0] <= 18'(cx) - 18'(bx);       ey_s[0] <= 18'(cy) - 18'(by_coord);
			qx_s[0] <= 18'({pixel_x, 4'd0}) - 18'(bx);
			qy_s[0] <= 18'({pixel_y, 4'd0}) - 18'(by_coord);
			ex_s[1] <= 18'(ax) - 18'(cx);       ey_s[1] <= 18'(ay) - 18'(cy);
			qx_s[1] <= 18'({pixel_x, 4'd0}) - 18'(cx);
			qy_s[1] <= 18'({pixel_y, 4'd0}) - 18'(cy);
			ex_s[2] <= 18'(bx) - 18'(ax);       ey_s[2] <= 18'(by_coord) - 18'(ay);
			qx_s[2] <= 18'({pixel_x, 4'd0}) - 18'(ax);
			qy_s[2] <= 18'({pixel_y, 4'd0}) - 18'(ay);
		end
		// phase 0: both products per edge registered, phase 1: difference
		if (state_q == ST_DIV && phase_q == 3'd0) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= 42'($signed(ex_s[i]) * $signed(qy_s[i]));
				edge_q[i] <= EdgeW'($signed(ey_s[i]) * $signed(qx_s[i]));
			end
		end
		if (state_q == ST_DIV && phase_q == 3'd1) begin
			for (int i = 0; i < 3; i++)
				edge_q[i] <= EdgeW'($signed(prod_q[i])) - edge_q[i];
		end
		if (state_q == ST_DIV && phase_q == 3'd2) total_q <= MagW'(tot_c);
		if (div_done) w_q[widx_q] <= div_quo;
		// depth: three products, then sum
		if (state_q == ST_DEPTH && phase_q == 3'd3) begin
			for (int i = 0; i < 3; i++) prod_q[i] <= 42'(rd_q[i] * w_q[i]);
		end
		if (state_q == ST_DEPTH && phase_q == 3'd4)
			depth_q <= DepthW'((prod_q[0] + prod_q[1] + prod_q[2]) >> 16);
	end

	tpcdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (MagW'(edge_q[div_idx])),
		.den    (total_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// depth store: read during the divide, written at the end
	assign mem_we    = (state_q == ST_WRITE) && (!act_q || depth_q < stored_q);
	assign mem_wdata = act_q ? depth_q : DepthMax;

	always_ff @(posedge clk) begin
		if (mem_we) store_mem[addr_q] <= mem_wdata;
		stored_q <= store_mem[addr_q];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= (state_q == ST_WRITE) || (state_q == ST_DIV && !run_q);
	end

	always_ff @(posedge clk) begin
		covered       <= (state_q == ST_WRITE) && act_q;
		depth_written <= (state_q == ST_WRITE) && act_q && depth_q < stored_q;
		pixel_depth   <= (state_q == ST_WRITE && act_q) ? depth_q : '0;
		weight_a      <= (state_q == ST_WRITE && act_q) ? w_q[0] : '0;
		weight_b      <= (state_q == ST_WRITE && act_q) ? w_q[1] : '0;
		weight_c      <= (state_q == ST_WRITE && act_q) ? w_q[2] : '0;
	end

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without item");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_write_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_WRITE) else $error("store write outside write step");

endmodule
